@@ hw/rtl/glzw_pkg.sv @@
// Shared types and constants for the GIF LZW decoder.
`timescale 1ns / 1ps
package glzw_pkg;
    localparam int DICT_AW   = 12;
    localparam int DICT_N    = 1 << DICT_AW;
    localparam int DEPTH_W   = DICT_AW + 1;
    localparam int PIX_W     = 27;
    localparam int MIN_W     = 4;
    localparam int CFG_W     = 27;

    localparam logic [MIN_W-1:0] MIN_LO     = 4'd2;
    localparam logic [MIN_W-1:0] MIN_HI     = 4'd11;
    localparam logic [MIN_W-1:0] MIN_RST    = 4'd8;
    localparam logic [MIN_W-1:0] MAX_CODE_W = 4'd12;
    localparam logic [PIX_W-1:0] TOTAL_RST  = 27'd1;

    localparam logic [2:0] ST_TAKEN   = 3'd0;
    localparam logic [2:0] ST_REFUSED = 3'd1;
    localparam logic [2:0] ST_PIXEL   = 3'd2;
    localparam logic [2:0] ST_PAD     = 3'd3;
    localparam logic [2:0] ST_NEED    = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    localparam logic [1:0] CAUSE_RUN  = 2'd0;
    localparam logic [1:0] CAUSE_STOP = 2'd1;
    localparam logic [1:0] CAUSE_BAD  = 2'd2;
    localparam logic [1:0] CAUSE_END  = 2'd3;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic CFG_MIN   = 1'b0;
    localparam logic CFG_TOTAL = 1'b1;

    typedef enum logic [1:0] {K_CLEAR, K_STOP, K_BAD, K_EXPAND} t_kind;

    typedef struct packed {
        logic       accept;
        logic       push;
        logic       fetch;
        logic       halt_end;
        logic       walk;
        logic       finish;
        logic       pop;
        logic       res_en;
        logic [2:0] res_status;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic  is_push;
        logic  frame_done;
        logic  stack_empty;
        logic  halted;
        logic  code_short;
        logic  stream_end;
        logic  walk_more;
        logic  out_free;
        t_kind kind;
    } t_sts;

    function automatic logic [MIN_W-1:0] eff_min(input logic [MIN_W-1:0] m);
        if (m < MIN_LO) return MIN_LO;
        if (m > MIN_HI) return MIN_HI;
        return m;
    endfunction
endpackage

@@ hw/rtl/glzw_ctrl.sv @@
// Sequencing state machine of the GIF LZW decoder.
`timescale 1ns / 1ps
module glzw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  glzw_pkg::t_sts i_sts,
    output glzw_pkg::t_cmd o_cmd
);
    import glzw_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_START  = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_WALK   = 8'b0000_1000,
        S_FINISH = 8'b0001_0000,
        S_POP    = 8'b0010_0000,
        S_EMIT   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_push) begin
                    o_cmd.push = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.frame_done) begin
                    o_cmd.res_en = 1'b1;
                    o_cmd.res_status = ST_DONE;
                    n_state = S_DONE;
                end else if (i_sts.stack_empty && !i_sts.halted) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_POP;
                end
            end
            S_FETCH: begin
                if (i_sts.code_short) begin
                    if (i_sts.stream_end) begin
                        o_cmd.halt_end = 1'b1;
                        n_state = S_POP;
                    end else begin
                        o_cmd.res_en = 1'b1;
                        o_cmd.res_status = ST_NEED;
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.fetch = 1'b1;
                    case (i_sts.kind)
                        K_CLEAR:  n_state = S_FETCH;
                        K_EXPAND: n_state = S_WALK;
                        default:  n_state = S_POP;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_sts.walk_more) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (i_sts.stack_empty) begin
                    o_cmd.res_en = 1'b1;
                    o_cmd.res_status = ST_PAD;
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.res_en = 1'b1;
                o_cmd.res_status = ST_PIXEL;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/glzw_dpath.sv @@
// Datapath of the GIF LZW decoder: bit buffer, dictionary, string stack, result.
`timescale 1ns / 1ps
module glzw_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [glzw_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_op,
    input  logic [7:0]                   i_byte,
    input  glzw_pkg::t_cmd               i_cmd,
    output glzw_pkg::t_sts               o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_pix,
    output logic                         o_last,
    output logic [1:0]                   o_cause
);
    import glzw_pkg::*;

    logic [MIN_W-1:0]   r_min, w_min, w_eff;
    logic [PIX_W-1:0]   r_total;
    logic               r_op;
    logic [7:0]         r_byte;
    logic [31:0]        r_buf;
    logic [5:0]         r_cnt;
    logic [7:0]         r_blk;
    logic               r_end;
    logic [DEPTH_W-1:0] r_depth, r_top, r_free;
    logic [MIN_W-1:0]   r_width;
    logic [DICT_AW-1:0] r_prior, r_code, r_cur;
    logic               r_pv, r_kw;
    logic [7:0]         r_first;
    logic [PIX_W-1:0]   r_pixels;
    logic               r_halted;
    logic [1:0]         r_hcause;
    logic [2:0]         r_res_status;
    logic [7:0]         r_res_pix;
    logic               r_res_last;
    logic [1:0]         r_res_cause;
    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic [7:0]         r_out_pix;
    logic               r_out_last;
    logic [1:0]         r_out_cause;

    logic [DICT_AW-1:0] r_prefix [DICT_N];
    logic [7:0]         r_suffix [DICT_N];
    logic [7:0]         r_stack  [DICT_N];
    logic [DICT_AW-1:0] r_pre_rd;
    logic [7:0]         r_suf_rd, r_stk_rd;

    logic [DEPTH_W-1:0] w_clear, w_code13, w_free_inc;
    logic [DEPTH_W-1:0] w_mask;
    logic [DICT_AW-1:0] w_code, w_start, w_raddr;
    logic               w_kw, w_stk_we;
    logic [DICT_AW-1:0] w_stk_wa;
    logic [7:0]         w_stk_wd;
    logic [PIX_W-1:0]   w_pix_inc;
    t_kind              w_kind;

    assign w_min      = (i_cfg_we && i_cfg_idx == CFG_MIN) ? i_cfg_data[MIN_W-1:0] : r_min;
    assign w_eff      = eff_min(w_min);
    assign w_clear    = DEPTH_W'(1) << w_eff;
    assign w_mask     = (DEPTH_W'(1) << r_width) - DEPTH_W'(1);
    assign w_code     = r_buf[DICT_AW-1:0] & w_mask[DICT_AW-1:0];
    assign w_code13   = {1'b0, w_code};
    assign w_kw       = (w_code13 == r_free);
    assign w_start    = w_kw ? r_prior : w_code;
    assign w_raddr    = i_cmd.walk ? r_pre_rd : w_start;
    assign w_free_inc = r_free + DEPTH_W'(1);
    assign w_pix_inc  = r_pixels + PIX_W'(1);

    always_comb begin
        if (w_code13 == w_clear) w_kind = K_CLEAR;
        else if (w_code13 == w_clear + DEPTH_W'(1)) w_kind = K_STOP;
        else if (w_code13 > r_free || (w_kw && !r_pv)) w_kind = K_BAD;
        else w_kind = K_EXPAND;
    end

    always_comb begin
        w_stk_we = 1'b0;
        w_stk_wa = r_top[DICT_AW-1:0];
        w_stk_wd = ({1'b0, r_cur} >= w_clear) ? r_suf_rd : r_cur[7:0];
        if (i_cmd.walk) begin
            w_stk_we = 1'b1;
        end else if (i_cmd.finish && r_kw) begin
            w_stk_we = 1'b1;
            w_stk_wa = '0;
            w_stk_wd = r_first;
        end
    end

    assign o_sts.is_push     = (r_op == OP_PUSH);
    assign o_sts.frame_done  = (r_pixels >= r_total);
    assign o_sts.stack_empty = (r_depth == '0);
    assign o_sts.halted      = r_halted;
    assign o_sts.code_short  = (r_cnt < {2'b00, r_width});
    assign o_sts.stream_end  = r_end;
    assign o_sts.walk_more   = ({1'b0, r_cur} >= w_clear);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.kind        = w_kind;

    // Dictionary and stack memories.
    always_ff @(posedge i_clk) begin
        r_pre_rd <= r_prefix[w_raddr];
        r_suf_rd <= r_suffix[w_raddr];
        r_stk_rd <= r_stack[DICT_AW'(r_depth - DEPTH_W'(1))];
        if (w_stk_we) r_stack[w_stk_wa] <= w_stk_wd;
        if (i_cmd.finish && r_pv && r_free < DEPTH_W'(DICT_N)) begin
            r_prefix[r_free[DICT_AW-1:0]] <= r_prior;
            r_suffix[r_free[DICT_AW-1:0]] <= r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_byte <= i_byte;
        end
        if (i_cmd.fetch) begin
            r_cur  <= w_start;
            r_code <= w_code;
            r_kw   <= w_kw;
        end
        if (i_cmd.walk) begin
            if ({1'b0, r_cur} >= w_clear) r_cur <= r_pre_rd;
            else r_first <= r_cur[7:0];
        end
        if (i_cmd.res_en) begin
            r_res_status <= i_cmd.res_status;
            r_res_pix    <= (i_cmd.res_status == ST_PIXEL) ? r_stk_rd : 8'd0;
            r_res_last   <= (i_cmd.res_status == ST_PIXEL || i_cmd.res_status == ST_PAD)
                            && (w_pix_inc == r_total);
            r_res_cause  <= r_halted ? r_hcause : CAUSE_RUN;
        end
        if (i_cmd.push) begin
            r_res_status <= (!r_end && r_blk != 8'd0 && r_cnt > 6'd24) ? ST_REFUSED : ST_TAKEN;
            r_res_pix    <= 8'd0;
            r_res_last   <= 1'b0;
            r_res_cause  <= r_halted ? r_hcause : CAUSE_RUN;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_pix    <= r_res_pix;
            r_out_last   <= r_res_last;
            r_out_cause  <= r_res_cause;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= MIN_RST;
            r_total     <= TOTAL_RST;
            r_out_valid <= 1'b0;
            r_buf       <= '0;
            r_cnt       <= '0;
            r_blk       <= '0;
            r_end       <= 1'b0;
            r_depth     <= '0;
            r_top       <= '0;
            r_free      <= (DEPTH_W'(1) << eff_min(MIN_RST)) + DEPTH_W'(2);
            r_width     <= eff_min(MIN_RST) + MIN_W'(1);
            r_prior     <= '0;
            r_pv        <= 1'b0;
            r_pixels    <= '0;
            r_halted    <= 1'b0;
            r_hcause    <= CAUSE_RUN;
        end else begin
            if (i_cmd.load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN) r_min <= i_cfg_data[MIN_W-1:0];
                else r_total <= i_cfg_data[PIX_W-1:0];
                r_buf    <= '0;
                r_cnt    <= '0;
                r_blk    <= '0;
                r_end    <= 1'b0;
                r_depth  <= '0;
                r_top    <= '0;
                r_free   <= w_clear + DEPTH_W'(2);
                r_width  <= w_eff + MIN_W'(1);
                r_prior  <= '0;
                r_pv     <= 1'b0;
                r_pixels <= '0;
                r_halted <= 1'b0;
                r_hcause <= CAUSE_RUN;
            end else begin
                if (i_cmd.push && !r_end) begin
                    if (r_blk == 8'd0) begin
                        if (r_byte == 8'd0) r_end <= 1'b1;
                        else r_blk <= r_byte;
                    end else if (r_cnt <= 6'd24) begin
                        r_buf <= r_buf | ({24'd0, r_byte} << r_cnt[4:0]);
                        r_cnt <= r_cnt + 6'd8;
                        r_blk <= r_blk - 8'd1;
                    end
                end
                if (i_cmd.halt_end) begin
                    r_halted <= 1'b1;
                    r_hcause <= CAUSE_END;
                end
                if (i_cmd.fetch) begin
                    r_buf <= r_buf >> r_width;
                    r_cnt <= r_cnt - {2'b00, r_width};
                    case (w_kind)
                        K_CLEAR: begin
                            r_free  <= w_clear + DEPTH_W'(2);
                            r_width <= w_eff + MIN_W'(1);
                            r_pv    <= 1'b0;
                        end
                        K_STOP: begin
                            r_halted <= 1'b1;
                            r_hcause <= CAUSE_STOP;
                        end
                        K_BAD: begin
                            r_halted <= 1'b1;
                            r_hcause <= CAUSE_BAD;
                        end
                        default: r_top <= w_kw ? DEPTH_W'(1) : DEPTH_W'(0);
                    endcase
                end
                if (i_cmd.walk) r_top <= r_top + DEPTH_W'(1);
                if (i_cmd.finish) begin
                    r_depth <= r_top;
                    r_prior <= r_code;
                    r_pv    <= 1'b1;
                    if (r_pv && r_free < DEPTH_W'(DICT_N)) begin
                        r_free <= w_free_inc;
                        if (w_free_inc == (DEPTH_W'(1) << r_width) && r_width < MAX_CODE_W)
                            r_width <= r_width + MIN_W'(1);
                    end
                end
                if (i_cmd.pop) r_depth <= r_depth - DEPTH_W'(1);
                if (i_cmd.res_en && (i_cmd.res_status == ST_PIXEL ||
                                     i_cmd.res_status == ST_PAD))
                    r_pixels <= w_pix_inc;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_pix       = r_out_pix;
    assign o_last      = r_out_last;
    assign o_cause     = r_out_cause;
endmodule

@@ hw/rtl/gif_lzw_decoder_core.sv @@
// GIF LZW decoder: push raw image bytes, pull pixel indices.
// Input channel s_axis: one beat is a push (tuser 0, tdata = raw image byte,
// sub-block length bytes included) or a pull (tuser 1, tdata ignored).
// Every beat gives exactly one result beat on m_axis: tuser = status
// (0 taken, 1 refused, 2 pixel, 3 padding, 4 need data, 5 frame complete),
// tdata = pixel index and stop cause, tlast = final pixel of the frame.
// A push passes through the start and done states; a pull that pops a stacked
// pixel passes through start, pop, emit and done; a pull that must fetch a
// code adds a fetch step per code read, a walk step per character of the
// code's string for the dictionary chain walk (one fewer when the code equals
// the next free code) and a finish step for the dictionary update. The chain
// walk goes through the single-read-port dictionary memory.
// One beat is worked on at a time; the next beat is taken once the result
// sits in the output register, even while the receiver stalls it.
// Configuration writes (index 0 min code size, 1 pixel total) restart the
// decoder; the user must make them only while idle (the block does not check).
// Reset restores min code size 8 and pixel total 1; no clearing pass needed.
`timescale 1ns / 1ps
module gif_lzw_decoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [glzw_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                 s_axis_tuser,  // [0] operation
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // [7:0] pixel_index, [9:8] stop_cause
    output logic [2:0]                 m_axis_tuser,  // [2:0] status
    output logic                       m_axis_tlast   // last_pixel
);
    import glzw_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [7:0] w_pix;
    logic [1:0] w_cause;

    glzw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    glzw_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser[0]),
        .i_byte      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_pix       (w_pix),
        .o_last      (m_axis_tlast),
        .o_cause     (w_cause)
    );

    assign m_axis_tdata = {6'd0, w_cause, w_pix};
endmodule
